/* hw/rtl/tbrd_pkg.sv */
// tbrd_pkg: shared types, codes and constants of the 2-bit dna region decoder
// used by every module of the block but tbrd_ram; depends on nothing
`default_nettype none

package tbrd_pkg;

  localparam int unsigned MAX_RUNS = 256;
  localparam int unsigned RUN_AW   = $clog2(MAX_RUNS);
  localparam int unsigned RUN_CW   = $clog2(MAX_RUNS + 1);
  localparam int unsigned RUN_DW   = 64;

  localparam logic [32:0] POS_LIMIT   = 33'h1_0000_0000;
  localparam logic [6:0]  CHAR_N      = 7'h4E;
  localparam logic [6:0]  CASE_OFFSET = 7'd32;

  localparam int unsigned CFG_AW = 3;

  typedef enum logic [1:0] {
    KIND_CLEAR    = 2'd0,
    KIND_N_RUN    = 2'd1,
    KIND_MASK_RUN = 2'd2,
    KIND_BYTE     = 2'd3
  } kind_t;

  typedef enum logic {
    REG_REGION_START = 1'b0,
    REG_REGION_END   = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] block_start;
    logic [31:0] block_size;
    logic [7:0]  packed_byte;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  base_char;
    logic [31:0] base_position;
    logic        last_of_byte;
    logic        region_done;
    logic        table_overflow;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic step;
    logic emit;
    logic next_base;
    logic finish;
  } tbrd_cmd_t;

  typedef struct packed {
    logic kind_byte;
    logic in_region;
    logic n_step;
    logic m_step;
    logic out_free;
    logic base_last;
  } tbrd_sts_t;

  function automatic logic [6:0] base_letter(input logic [1:0] code);
    logic [6:0] c;
    begin
      unique case (code)
        2'd0: c = 7'h54;
        2'd1: c = 7'h43;
        2'd2: c = 7'h41;
        default: c = 7'h47;
      endcase
      return c;
    end
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tbrd_ram.sv */
// tbrd_ram: generic simple dual-port ram, one write and one registered read port
// standalone, no package needed
`default_nettype none

module tbrd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hw/rtl/tbrd_ctrl.sv */
// tbrd_ctrl: sequencer of the decoder, walks the four bases of a packed byte
// depends on tbrd_pkg
`default_nettype none

module tbrd_ctrl
  import tbrd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire tbrd_sts_t sts,
  output tbrd_cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.kind_byte) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (!sts.in_region) begin
          if (sts.base_last) state_nxt = ST_IDLE;
        end else if (sts.n_step || sts.m_step) begin
          state_nxt = ST_READ;
        end else if (sts.out_free && sts.base_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_READ: ;
      ST_EVAL: begin
        if (!sts.in_region) begin
          cmd.finish    = sts.base_last;
          cmd.next_base = !sts.base_last;
        end else if (sts.n_step || sts.m_step) begin
          cmd.step = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.finish    = sts.base_last;
          cmd.next_base = !sts.base_last;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/tbrd_dp.sv */
// tbrd_dp: datapath of the decoder, region registers, run tables, cursors
// and the output register; depends on tbrd_pkg and tbrd_ram
`default_nettype none

module tbrd_dp
  import tbrd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire in_item_t          in_data,
  input  wire tbrd_cmd_t         cmd,
  output tbrd_sts_t              sts,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata
);

  logic [31:0]       rstart_r, rend_r;
  logic [RUN_CW-1:0] n_cnt_r, n_cnt_nxt, m_cnt_r, m_cnt_nxt;
  logic [RUN_CW-1:0] n_cur_r, n_cur_nxt, m_cur_r, m_cur_nxt;
  logic [32:0]       nbb_r, nbb_nxt;
  logic              ovf_r, ovf_nxt;
  logic [32:0]       pos_r, pos_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic [1:0]        k_r, k_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r;

  logic              cfg_wr;
  logic              n_we, m_we;
  logic [RUN_DW-1:0] run_wdata, n_rdata, m_rdata;
  logic [32:0]       n_end, m_end, pos_inc;
  logic              n_live, m_live, n_hit, m_hit;
  logic [6:0]        ch;

  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rstart_r <= '0;
      rend_r   <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_REGION_START) rstart_r <= pwdata;
      else rend_r <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_REGION_START) ? rstart_r : rend_r;

  // run tables, entry is {start, size}
  assign run_wdata = {in_data.block_start, in_data.block_size};
  assign n_we = cmd.take && (in_data.kind == KIND_N_RUN) && (n_cnt_r < RUN_CW'(MAX_RUNS));
  assign m_we = cmd.take && (in_data.kind == KIND_MASK_RUN) && (m_cnt_r < RUN_CW'(MAX_RUNS));

  tbrd_ram #(.WIDTH(RUN_DW), .DEPTH(MAX_RUNS)) u_n_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_cnt_r[RUN_AW-1:0]),
    .wdata (run_wdata),
    .raddr (n_cur_r[RUN_AW-1:0]),
    .rdata (n_rdata)
  );

  tbrd_ram #(.WIDTH(RUN_DW), .DEPTH(MAX_RUNS)) u_m_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_cnt_r[RUN_AW-1:0]),
    .wdata (run_wdata),
    .raddr (m_cur_r[RUN_AW-1:0]),
    .rdata (m_rdata)
  );

  assign n_end  = {1'b0, n_rdata[63:32]} + {1'b0, n_rdata[31:0]};
  assign m_end  = {1'b0, m_rdata[63:32]} + {1'b0, m_rdata[31:0]};
  assign n_live = n_cur_r < n_cnt_r;
  assign m_live = m_cur_r < m_cnt_r;
  assign n_hit  = n_live && ({1'b0, n_rdata[63:32]} <= pos_r);
  assign m_hit  = m_live && ({1'b0, m_rdata[63:32]} <= pos_r);
  assign pos_inc = pos_r + 33'd1;

  always_comb begin
    sts.kind_byte = in_data.kind == KIND_BYTE;
    sts.in_region = (pos_r >= {1'b0, rstart_r}) && (pos_r < {1'b0, rend_r});
    sts.n_step    = n_live && (n_end <= pos_r);
    sts.m_step    = m_live && (m_end <= pos_r);
    sts.out_free  = !out_valid_r || out_ready;
    sts.base_last = k_r == 2'd3;
  end

  always_comb begin
    ch = n_hit ? CHAR_N : base_letter(byte_r[7:6]);
    if (m_hit) ch = ch + CASE_OFFSET;
  end

  always_comb begin
    n_cnt_nxt = n_cnt_r;
    m_cnt_nxt = m_cnt_r;
    n_cur_nxt = n_cur_r;
    m_cur_nxt = m_cur_r;
    nbb_nxt   = nbb_r;
    ovf_nxt   = ovf_r;
    pos_nxt   = pos_r;
    byte_nxt  = byte_r;
    k_nxt     = k_r;
    if (cmd.take) begin
      case (in_data.kind)
        KIND_CLEAR: begin
          n_cnt_nxt = '0;
          m_cnt_nxt = '0;
          n_cur_nxt = '0;
          m_cur_nxt = '0;
          ovf_nxt   = 1'b0;
          nbb_nxt   = {1'b0, rstart_r[31:2], 2'b00};
        end
        KIND_N_RUN: begin
          if (n_we) n_cnt_nxt = n_cnt_r + RUN_CW'(1);
          else ovf_nxt = 1'b1;
        end
        KIND_MASK_RUN: begin
          if (m_we) m_cnt_nxt = m_cnt_r + RUN_CW'(1);
          else ovf_nxt = 1'b1;
        end
        default: begin
          pos_nxt  = nbb_r;
          byte_nxt = in_data.packed_byte;
          k_nxt    = 2'd0;
        end
      endcase
    end
    if (cmd.step) begin
      if (sts.n_step) n_cur_nxt = n_cur_r + RUN_CW'(1);
      if (sts.m_step) m_cur_nxt = m_cur_r + RUN_CW'(1);
    end
    if (cmd.next_base) begin
      pos_nxt  = pos_inc;
      byte_nxt = {byte_r[5:0], 2'b00};
      k_nxt    = k_r + 2'd1;
    end
    if (cmd.finish && (nbb_r < POS_LIMIT)) begin
      nbb_nxt = nbb_r + 33'd4;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_cnt_r     <= '0;
      m_cnt_r     <= '0;
      n_cur_r     <= '0;
      m_cur_r     <= '0;
      nbb_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      n_cnt_r     <= n_cnt_nxt;
      m_cnt_r     <= m_cnt_nxt;
      n_cur_r     <= n_cur_nxt;
      m_cur_r     <= m_cur_nxt;
      nbb_r       <= nbb_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    byte_r <= byte_nxt;
    k_r    <= k_nxt;
    if (cmd.emit) begin
      out_r.base_char      <= ch;
      out_r.base_position  <= pos_r[31:0];
      out_r.last_of_byte   <= sts.base_last || (pos_inc == {1'b0, rend_r});
      out_r.region_done    <= pos_inc == {1'b0, rend_r};
      out_r.table_overflow <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* hw/rtl/twobit_dna_region_decoder.sv */
// twobit_dna_region_decoder: top level, sequencer plus datapath
// depends on tbrd_pkg, tbrd_ctrl, tbrd_dp and tbrd_ram
`default_nettype none

// Decodes a 2-bit packed dna record over [region_start, region_end). A clear
// item opens a record, n-run and mask-run items fill two 256-entry tables,
// and packed-byte items then yield up to four bases each. Clear and run items
// are taken straight from ST_IDLE. A packed byte passes through ST_READ to
// ST_EVAL, which handles its four bases in turn; every cursor step, where one
// step moves either run cursor or both past one table entry, goes back through
// ST_READ, since each step re-reads the run table memory through its registered
// read port. A base inside the region also waits in ST_EVAL while the output
// register stays full. A finished base waits in the output register, so the
// next item is taken while the last base of a byte is still pending.

module twobit_dna_region_decoder
  import tbrd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  tbrd_cmd_t cmd;
  tbrd_sts_t sts;

  assign pready = 1'b1;

  tbrd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tbrd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
  );

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("base loaded over a pending result");

  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> !in_ready)
    else $error("input taken while a run lookup is in flight");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.region_done) |-> out_data.last_of_byte)
    else $error("region end not marked as last base of its byte");

  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("result appeared without an emit");

endmodule

`default_nettype wire
